// ===== rtl/bswf_pkg.sv =====
// Shared types and constants of the byte-stuffing word framer.
`timescale 1ns / 1ps

package bswf_pkg;

   // Payload widths
   localparam int BYTE_W         = 8;
   localparam int DATA_W         = 64;
   localparam int MAX_WORD_BYTES = DATA_W / BYTE_W;
   localparam int WORD_BYTES_DEF = 8;

   // Register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_START_BYTE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_BYTE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_BYTE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_MASK = 2'd3;

   localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'h12;
   localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'h13;
   localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'h7D;
   localparam logic [BYTE_W-1:0] ESCAPE_MASK_RST = 8'h20;

   // Marker values every cell compares its byte against
   typedef struct packed {
      logic [BYTE_W-1:0] start_val;
      logic [BYTE_W-1:0] end_val;
      logic [BYTE_W-1:0] esc_val;
   } marker_set_type;

endpackage

// ===== rtl/bswf_req_if.sv =====
// Request channel: one 64-bit word to frame.
`timescale 1ns / 1ps

interface bswf_req_if;
   logic                        valid;
   logic                        ready;
   logic [bswf_pkg::DATA_W-1:0] data_word;

   modport source (output valid, output data_word, input ready);
   modport sink   (input valid, input data_word, output ready);
endinterface

// ===== rtl/bswf_rsp_if.sv =====
// Response channel: one byte of the framed stream.
`timescale 1ns / 1ps

interface bswf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bswf_pkg::BYTE_W-1:0] out_byte;
   logic                        frame_last;

   modport source (output valid, output out_byte, output frame_last, input ready);
   modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface

// ===== rtl/bswf_cell.sv =====
// One byte cell of the data chain: holds a byte, flags a marker clash, hands it on.
`timescale 1ns / 1ps

module bswf_cell (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           shift,
   input  logic [bswf_pkg::BYTE_W-1:0]    load_byte,
   input  logic [bswf_pkg::BYTE_W-1:0]    next_byte,
   input  bswf_pkg::marker_set_type       markers,
   output logic [bswf_pkg::BYTE_W-1:0]    cell_byte,
   output logic                           cell_hit
);

   logic [bswf_pkg::BYTE_W-1:0] data_ff;
   logic [bswf_pkg::BYTE_W-1:0] data_in;

   // Load a new word byte, or take the neighbor's byte on a shift
   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_byte;
      end else if (shift) begin
         data_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Flag a byte that collides with any marker
   assign cell_byte = data_ff;
   assign cell_hit  = (data_ff == markers.start_val) ||
                      (data_ff == markers.end_val)   ||
                      (data_ff == markers.esc_val);

endmodule

// ===== rtl/byte_stuffing_word_framer_unit.sv =====
// Byte-stuffing word framer: a chain of byte cells drained by a frame sequencer.
`timescale 1ns / 1ps

// Takes one word per request and sends it as a frame, one byte per cycle while
// the response side accepts: the start marker, the WORD_BYTES low bytes least
// significant first, then the end marker flagged with frame_last. A data byte
// equal to the start, end or escape marker goes out as the escape byte followed
// by the byte XORed with the escape mask. The word is held in a row of byte
// cells that shifts toward the head as bytes leave. One request is in flight at
// a time, and each byte goes out through a single registered response byte.
// The user must write registers through the csr_ port only while no frame is in
// progress; the block itself does not enforce this.

module byte_stuffing_word_framer_unit #(
   parameter int WORD_BYTES = bswf_pkg::WORD_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   bswf_req_if.sink                         req_chan,
   bswf_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [bswf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bswf_pkg::BYTE_W-1:0]      csr_wdata
);

   // Cap the data bytes at the width of the word
   localparam int DATA_BYTES = (WORD_BYTES > bswf_pkg::MAX_WORD_BYTES) ?
                               bswf_pkg::MAX_WORD_BYTES : WORD_BYTES;
   localparam int CNT_W = $clog2(DATA_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DATA_BYTES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DATA,
      ST_ESC,
      ST_END
   } state_type;

   // Configuration registers
   logic [bswf_pkg::BYTE_W-1:0] start_ff;
   logic [bswf_pkg::BYTE_W-1:0] end_ff;
   logic [bswf_pkg::BYTE_W-1:0] escape_ff;
   logic [bswf_pkg::BYTE_W-1:0] mask_ff;

   // Sequencer and response register
   state_type                   state_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        rsp_valid_ff;
   logic [bswf_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                        rsp_last_ff;

   logic                        req_fire;
   logic                        slot_free;
   logic                        advance;
   logic                        shift;
   bswf_pkg::marker_set_type    markers;
   logic [bswf_pkg::BYTE_W-1:0] cell_bytes [DATA_BYTES];
   logic [DATA_BYTES-1:0]       cell_hits;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= bswf_pkg::START_BYTE_RST;
         end_ff    <= bswf_pkg::END_BYTE_RST;
         escape_ff <= bswf_pkg::ESCAPE_BYTE_RST;
         mask_ff   <= bswf_pkg::ESCAPE_MASK_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            bswf_pkg::REG_START_BYTE:  start_ff  <= csr_wdata;
            bswf_pkg::REG_END_BYTE:    end_ff    <= csr_wdata;
            bswf_pkg::REG_ESCAPE_BYTE: escape_ff <= csr_wdata;
            bswf_pkg::REG_ESCAPE_MASK: mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign markers.start_val = start_ff;
   assign markers.end_val   = end_ff;
   assign markers.esc_val   = escape_ff;

   // Handshake and chain control
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = slot_free &&
                           (state_ff inside {ST_START, ST_DATA, ST_ESC, ST_END});
   assign shift          = advance &&
                           ((state_ff == ST_ESC) || ((state_ff == ST_DATA) && !cell_hits[0]));

   // Chain of byte cells, head at index 0
   for (genvar i = 0; i < DATA_BYTES; i++) begin : g_cell
      logic [bswf_pkg::BYTE_W-1:0] next_byte;
      if (i == DATA_BYTES - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_body
         assign next_byte = cell_bytes[i+1];
      end
      bswf_cell u_cell (
         .clock     (clock),
         .load      (req_fire),
         .shift     (shift),
         .load_byte (req_chan.data_word[bswf_pkg::BYTE_W*i +: bswf_pkg::BYTE_W]),
         .next_byte (next_byte),
         .markers   (markers),
         .cell_byte (cell_bytes[i]),
         .cell_hit  (cell_hits[i])
      );
   end

   // Sequence the frame and hold the response byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         // Raise valid on a new byte, drop it once the held byte is taken
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (slot_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (advance) begin
                  rsp_byte_ff  <= start_ff;
                  rsp_last_ff  <= 1'b0;
                  cnt_ff       <= CNT_FULL;
                  state_ff     <= ST_DATA;
               end
            end
            ST_DATA: begin
               if (advance) begin
                  rsp_last_ff  <= 1'b0;
                  if (cell_hits[0]) begin
                     rsp_byte_ff <= escape_ff;
                     state_ff    <= ST_ESC;
                  end else begin
                     rsp_byte_ff <= cell_bytes[0];
                     cnt_ff      <= cnt_ff - CNT_ONE;
                     state_ff    <= (cnt_ff == CNT_ONE) ? ST_END : ST_DATA;
                  end
               end
            end
            ST_ESC: begin
               if (advance) begin
                  rsp_last_ff  <= 1'b0;
                  rsp_byte_ff  <= cell_bytes[0] ^ mask_ff;
                  cnt_ff       <= cnt_ff - CNT_ONE;
                  state_ff     <= (cnt_ff == CNT_ONE) ? ST_END : ST_DATA;
               end
            end
            ST_END: begin
               if (advance) begin
                  rsp_last_ff  <= 1'b1;
                  rsp_byte_ff  <= end_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.frame_last = rsp_last_ff;

`ifndef SYNTHESIS
   // An accepted request always opens with the start marker
   a_req_starts_frame: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_START))
      else $error("accepted request did not start a frame");

   // Data bytes remain whenever a data byte or its escaped form is due
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DATA) || (state_ff == ST_ESC)) |-> (cnt_ff != '0))
      else $error("data phase with no bytes left");

   // The end marker follows only once every data byte has left the chain
   a_end_after_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END) |-> (cnt_ff == '0))
      else $error("end marker before all data bytes were sent");
`endif

endmodule

// ===== bench/byte_stuffing_word_framer_unit_test.sv =====
// Testbench for the byte-stuffing word framer: predicts every frame and checks it byte by byte.
`timescale 1ns / 1ps

module byte_stuffing_word_framer_unit_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_SHOWN    = 10;
   localparam int PHASE_WORDS  = 32;
   localparam int FRAME_DATA_BYTES =
      (bswf_pkg::WORD_BYTES_DEF > bswf_pkg::MAX_WORD_BYTES) ?
      bswf_pkg::MAX_WORD_BYTES : bswf_pkg::WORD_BYTES_DEF;

   typedef struct packed {
      logic [bswf_pkg::BYTE_W-1:0] value;
      logic                        last;
   } frame_byte_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [bswf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bswf_pkg::BYTE_W-1:0]    csr_wdata = '0;

   bswf_req_if req_if();
   bswf_rsp_if rsp_if();

   // Shadow copy of the marker registers
   logic [bswf_pkg::BYTE_W-1:0] start_mark;
   logic [bswf_pkg::BYTE_W-1:0] end_mark;
   logic [bswf_pkg::BYTE_W-1:0] escape_mark;
   logic [bswf_pkg::BYTE_W-1:0] escape_xor;

   frame_byte_type bytes_due[$];
   int             words_sent    = 0;
   int             bytes_checked = 0;
   int             mismatches    = 0;
   int             settings_used = 1;
   bit             gaps_on       = 1'b0;

   byte_stuffing_word_framer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Build the expected frame of one word from the current markers
   function automatic void predict_frame(input logic [bswf_pkg::DATA_W-1:0] word);
      logic [bswf_pkg::BYTE_W-1:0] b;
      bytes_due.push_back('{value: start_mark, last: 1'b0});
      for (int i = 0; i < FRAME_DATA_BYTES; i++) begin
         b = word[i*bswf_pkg::BYTE_W +: bswf_pkg::BYTE_W];
         if (b == start_mark || b == end_mark || b == escape_mark) begin
            bytes_due.push_back('{value: escape_mark, last: 1'b0});
            b = b ^ escape_xor;
         end
         bytes_due.push_back('{value: b, last: 1'b0});
      end
      bytes_due.push_back('{value: end_mark, last: 1'b1});
   endfunction

   // Favor marker values and the start marker's escaped image so that stuffing happens often
   function automatic logic [bswf_pkg::BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 5))
         0:       return start_mark;
         1:       return end_mark;
         2:       return escape_mark;
         3:       return start_mark ^ escape_xor;
         default: return bswf_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [bswf_pkg::DATA_W-1:0] pick_word();
      logic [bswf_pkg::DATA_W-1:0] w;
      if ($urandom_range(0, 6) == 0) begin
         w = {$urandom, $urandom};
      end else begin
         for (int i = 0; i < bswf_pkg::MAX_WORD_BYTES; i++)
            w[i*bswf_pkg::BYTE_W +: bswf_pkg::BYTE_W] = pick_byte();
      end
      return w;
   endfunction

   function automatic logic [bswf_pkg::BYTE_W-1:0] pick_setting();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return bswf_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one request, hold it until accepted, then record its frame
   task automatic send_word(input logic [bswf_pkg::DATA_W-1:0] word);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_word <= word;
      do @(posedge clock); while (!req_if.ready);
      predict_frame(word);
      words_sent++;
   endtask

   // Drop valid and wait until every expected byte has come out
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bswf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bswf_pkg::BYTE_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         bswf_pkg::REG_START_BYTE:  start_mark  = value;
         bswf_pkg::REG_END_BYTE:    end_mark    = value;
         bswf_pkg::REG_ESCAPE_BYTE: escape_mark = value;
         bswf_pkg::REG_ESCAPE_MASK: escape_xor  = value;
         default: ;
      endcase
   endtask

   task automatic set_markers(input logic [bswf_pkg::BYTE_W-1:0] s,
                              input logic [bswf_pkg::BYTE_W-1:0] e,
                              input logic [bswf_pkg::BYTE_W-1:0] x,
                              input logic [bswf_pkg::BYTE_W-1:0] m);
      wait_drained();
      write_reg(bswf_pkg::REG_START_BYTE, s);
      write_reg(bswf_pkg::REG_END_BYTE, e);
      write_reg(bswf_pkg::REG_ESCAPE_BYTE, x);
      write_reg(bswf_pkg::REG_ESCAPE_MASK, m);
      settings_used++;
   endtask

   // Reset markers: plain bytes, every marker in the data, longest frame
   task automatic test_reset_markers();
      gaps_on = 1'b0;
      send_word(64'h0000_0000_0000_0000);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h1213_7D00_7D13_1201);
      send_word(64'h7D7D_7D7D_7D7D_7D7D);
      send_word(64'h3233_5D32_3380_5D01);
      send_word(64'h8000_0000_0000_0001);
   endtask

   // All three markers the same value, then the extreme register values
   task automatic test_coinciding_markers();
      gaps_on = 1'b1;
      set_markers(8'h55, 8'h55, 8'h55, 8'hFF);
      send_word(64'h5555_5555_5555_5555);
      send_word(64'hAA55_00AA_55FF_5501);
      set_markers(8'h00, 8'hFF, 8'h00, 8'hFF);
      send_word(64'h0000_0000_0000_0000);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h00FF_FF00_1234_00FF);
   endtask

   // Escaped value lands on a marker and goes out unescaped
   task automatic test_escape_hits_marker();
      gaps_on = 1'b1;
      set_markers(8'h12, 8'h32, 8'h7D, 8'h20);
      send_word(64'h1232_7D12_5D32_0012);
      send_word(64'h1212_1212_1212_1212);
      set_markers(8'h12, 8'h13, 8'h7D, 8'h00);
      send_word(64'h1213_7D12_137D_0102);
      send_word(64'h7D7D_1313_1212_7D00);
   endtask

   // Hold each request until the previous frame has fully drained
   task automatic test_drain_pause();
      gaps_on = 1'b1;
      set_markers(pick_setting(), pick_setting(), pick_setting(), pick_setting());
      repeat (5) begin
         send_word(pick_word());
         wait_drained();
      end
   endtask

   // Random marker settings, each followed by a burst of words
   task automatic test_random_traffic();
      logic [bswf_pkg::BYTE_W-1:0] s;
      for (int phase = 0; phase < 6; phase++) begin
         gaps_on = (phase % 2) == 0;
         s = pick_setting();
         if (phase % 3 == 2) set_markers(s, s, pick_setting(), pick_setting());
         else set_markers(s, pick_setting(), pick_setting(), pick_setting());
         repeat (PHASE_WORDS) send_word(pick_word());
      end
   endtask

   // Compare each accepted byte with the oldest expected one
   always @(posedge clock) begin : frame_check
      frame_byte_type due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected byte %h last %b", rsp_if.out_byte, rsp_if.frame_last);
         end else begin
            due = bytes_due.pop_front();
            bytes_checked++;
            if (rsp_if.out_byte !== due.value || rsp_if.frame_last !== due.last) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("byte %0d: expected %h last %b, got %h last %b", bytes_checked,
                           due.value, due.last, rsp_if.out_byte, rsp_if.frame_last);
            end
         end
      end
   end

   // Stall the response side for a random number of cycles per byte while gaps are on
   initial begin : rsp_stall
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = gaps_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d bytes still due", CYCLE_LIMIT, bytes_due.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : main_seq
      req_if.valid     = 1'b0;
      req_if.data_word = '0;
      rsp_if.ready     = 1'b0;
      start_mark       = bswf_pkg::START_BYTE_RST;
      end_mark         = bswf_pkg::END_BYTE_RST;
      escape_mark      = bswf_pkg::ESCAPE_BYTE_RST;
      escape_xor       = bswf_pkg::ESCAPE_MASK_RST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_markers();
      test_coinciding_markers();
      test_escape_hits_marker();
      test_drain_pause();
      test_random_traffic();

      wait_drained();
      repeat (20) @(posedge clock);
      $display("checked %0d bytes from %0d words under %0d marker settings",
               bytes_checked, words_sent, settings_used);
      $display("covered reset, coinciding and extreme markers, zero mask, and stalled traffic");
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
